### src/urla_pkg.sv
`default_nettype none

package urla_pkg;

  // Receiver phase within a frame
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHIFT = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  localparam logic [7:0] DIVISOR_RESET      = 8'd4;
  localparam logic [7:0] NEWLINE_CODE       = 8'h0A;
  localparam logic [3:0] DATA_BITS          = 4'd8;
  localparam int         LINE_BYTES_DEFAULT = 256;

  // One input word: one system clock item
  typedef struct packed {
    logic clear;
    logic tick;
    logic rx_level;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic [7:0] byte_position;
    logic       line_done;
    logic       framing_error;
    logic       line_overflow;
    logic       line_ready;
    logic       clear_to_send;
  } out_word_t;

endpackage

`default_nettype wire

### src/urla_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one word per handshake
interface urla_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/uart_receiver_line_assembler.sv
// 8N1 UART receiver with line assembly. Each input word is one system clock
// item (clear, tick, rx_level) and yields exactly one result word. While the
// skid is empty, one word is accepted every cycle: all per-item work is a
// single pass of short logic from the receiver state registers into the
// result register, and a two-entry output stage (result register plus skid
// register) keeps in_chan ready while one finished word waits on out_chan.
// in_chan.ready drops only when both output entries are full. The bit period
// is 8*(1+baud_divisor) ticks; baud_divisor resets to 4 and is written
// through cfg_chan, which is always ready and must only be written while
// idle. LINE_BYTES sets how many bytes a line holds before line_overflow.
`default_nettype none

module uart_receiver_line_assembler
  import urla_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEFAULT
) (
  input  wire           clk,
  input  wire           rst_n,
  urla_stream_if.sink   in_chan,
  urla_stream_if.source out_chan,
  urla_stream_if.sink   cfg_chan
);

  localparam int              CNT_W    = $clog2(LINE_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BYTES);
  localparam logic [7:0]       LAST_POS = 8'(LINE_BYTES - 1);

  // Receiver state
  phase_t           phase_r,      phase_nxt;
  logic [10:0]      tick_count_r, tick_count_nxt;
  logic [7:0]       shift_r,      shift_nxt;
  logic [3:0]       bit_count_r,  bit_count_nxt;
  logic [CNT_W-1:0] char_count_r, char_count_nxt;
  logic             ready_flag_r, ready_flag_nxt;
  logic             cts_flag_r,   cts_flag_nxt;
  logic [7:0]       divisor_r;

  // Output stage
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r,  out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t skid_data_r,  skid_data_nxt;

  in_word_t  in_word;
  out_word_t res;
  logic      accept;
  logic      drain;
  logic      act;
  logic [11:0] next_count;
  logic [11:0] period;
  logic [8:0]  div_plus1;

  assign in_word        = in_chan.data;
  assign in_chan.ready  = ~skid_valid_r;
  assign accept         = in_chan.valid & ~skid_valid_r;
  assign drain          = out_valid_r & out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign cfg_chan.ready = 1'b1;

  // Bit period timing
  assign div_plus1  = {1'b0, divisor_r} + 9'd1;
  assign period     = {div_plus1, 3'b000};
  assign next_count = {1'b0, tick_count_r} + 12'd1;
  assign act        = (phase_r == PH_IDLE) || (next_count >= period);

  // Advance the receiver for one accepted word and form its result
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    shift_nxt      = shift_r;
    bit_count_nxt  = bit_count_r;
    char_count_nxt = char_count_r;
    ready_flag_nxt = ready_flag_r;
    cts_flag_nxt   = cts_flag_r;
    res            = '0;

    if (accept) begin
      if (in_word.clear) begin
        phase_nxt      = PH_IDLE;
        tick_count_nxt = '0;
        shift_nxt      = '0;
        bit_count_nxt  = '0;
        char_count_nxt = '0;
        ready_flag_nxt = 1'b0;
        cts_flag_nxt   = 1'b1;
      end else if (in_word.tick) begin
        if (!act) begin
          tick_count_nxt = tick_count_r + 11'd1;
        end else begin
          tick_count_nxt = '0;
          cts_flag_nxt   = 1'b0;
          unique case (phase_r)
            PH_SHIFT: begin
              shift_nxt     = {in_word.rx_level, shift_r[7:1]};
              bit_count_nxt = bit_count_r + 4'd1;
              if (bit_count_nxt >= DATA_BITS) begin
                phase_nxt = PH_STOP;
              end
            end
            PH_STOP: begin
              phase_nxt = PH_IDLE;
              if (in_word.rx_level) begin
                res.byte_valid = 1'b1;
                res.rx_byte    = shift_r;
                if (char_count_r >= CNT_FULL) begin
                  res.line_overflow = 1'b1;
                  res.byte_position = LAST_POS;
                end else begin
                  res.byte_position = 8'(char_count_r);
                  char_count_nxt    = char_count_r + CNT_W'(1);
                end
                // Newline closes the line
                if (shift_r == NEWLINE_CODE) begin
                  res.line_done  = 1'b1;
                  char_count_nxt = '0;
                  ready_flag_nxt = 1'b1;
                end
              end else begin
                res.framing_error = 1'b1;
                char_count_nxt    = '0;
              end
            end
            default: begin
              phase_nxt     = in_word.rx_level ? PH_IDLE : PH_SHIFT;
              bit_count_nxt = '0;
            end
          endcase
        end
      end
    end

    res.line_ready    = ready_flag_nxt;
    res.clear_to_send = cts_flag_nxt;
  end

  // Route results through result register and skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || drain) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_data_nxt  = res;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      shift_r      <= '0;
      bit_count_r  <= '0;
      char_count_r <= '0;
      ready_flag_r <= 1'b0;
      cts_flag_r   <= 1'b1;
      divisor_r    <= DIVISOR_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      shift_r      <= shift_nxt;
      bit_count_r  <= bit_count_nxt;
      char_count_r <= char_count_nxt;
      ready_flag_r <= ready_flag_nxt;
      cts_flag_r   <= cts_flag_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_chan.valid) begin
        divisor_r <= cfg_chan.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // Skid entry is only used behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty result register");

  // Stop phase is reached only after all data bits
  a_stop_after_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) |-> (bit_count_r == DATA_BITS))
    else $error("stop phase with incomplete data bits");

  // Bit counter never passes the frame width
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= DATA_BITS)
    else $error("bit counter out of range");

  // Line count saturates at the buffer size
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= CNT_FULL)
    else $error("line count beyond buffer size");

  // Tick counter rests at zero while idle
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_count_r == '0))
    else $error("tick counter running while idle");

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import urla_pkg::*;

  localparam int LINE_LEN    = LINE_BYTES_DEFAULT;
  localparam int QUIET_LIMIT = 1000;

  // Line high with the clock ticking: the idle state of a serial line
  localparam in_word_t IDLE_TICK = '{clear: 1'b0, tick: 1'b1, rx_level: 1'b1};

  typedef enum logic [2:0] {
    ST_LEVEL,  // hold the line at one level for count words
    ST_FRAME,  // one full frame up to the stop-bit sample
    ST_PART,   // first count ticks of a frame only
    ST_FILL,   // count good frames, no newline among them
    ST_CLEAR,  // one clear word
    ST_BAUD    // write the baud divisor
  } step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [7:0] val;
    logic       stop_lvl;
    logic       tick_on;
    int         count;
    logic       typed_on;
    out_word_t  typed;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  urla_stream_if #(.word_t(in_word_t))   in_chan ();
  urla_stream_if #(.word_t(out_word_t))  out_chan ();
  urla_stream_if #(.word_t(logic [7:0])) cfg_chan ();

  uart_receiver_line_assembler #(
    .LINE_BYTES(LINE_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver state as the predictor sees it
  logic [7:0]  baud_div;
  phase_t      rx_ph;
  logic [10:0] tick_cnt;
  logic [7:0]  shift_bits;
  logic [3:0]  bits_taken;
  int          held_chars;
  bit          line_seen;
  bit          cts_state;

  out_word_t   expected_q[$];
  int          mismatch_count = 0;
  int          live_words = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  function automatic void clear_rx_state();
    rx_ph      = PH_IDLE;
    tick_cnt   = '0;
    shift_bits = '0;
    bits_taken = '0;
    held_chars = 0;
    line_seen  = 1'b0;
    cts_state  = 1'b1;
  endfunction

  // Advance the receiver by one word and return the result word it gives
  function automatic out_word_t predict_rx(in_word_t w);
    out_word_t r;
    int        nxt;
    int        period;
    bit        act;
    r = '0;
    if (w.clear) begin
      clear_rx_state();
    end else if (w.tick) begin
      act = 1'b1;
      // count ticks inside a bit period; idle polls every tick
      if (rx_ph != PH_IDLE) begin
        period = 8 * (1 + int'(baud_div));
        nxt = int'(tick_cnt) + 1;
        if (nxt < period) begin
          tick_cnt = nxt[10:0];
          act = 1'b0;
        end
      end
      if (act) begin
        tick_cnt  = '0;
        cts_state = 1'b0;
        case (rx_ph)
          PH_SHIFT: begin
            shift_bits = {w.rx_level, shift_bits[7:1]};
            bits_taken = bits_taken + 4'd1;
            if (bits_taken >= DATA_BITS) rx_ph = PH_STOP;
          end
          PH_STOP: begin
            rx_ph = PH_IDLE;
            if (w.rx_level) begin
              r.byte_valid = 1'b1;
              r.rx_byte    = shift_bits;
              // saturate the position once the line is full
              if (held_chars >= LINE_LEN) begin
                r.line_overflow = 1'b1;
                r.byte_position = 8'(LINE_LEN - 1);
              end else begin
                r.byte_position = 8'(held_chars);
                held_chars++;
              end
              if (shift_bits == NEWLINE_CODE) begin
                r.line_done = 1'b1;
                held_chars  = 0;
                line_seen   = 1'b1;
              end
            end else begin
              r.framing_error = 1'b1;
              held_chars      = 0;
            end
          end
          default: begin
            rx_ph      = w.rx_level ? PH_IDLE : PH_SHIFT;
            bits_taken = '0;
          end
        endcase
      end
    end
    r.line_ready    = line_seen;
    r.clear_to_send = cts_state;
    return r;
  endfunction

  function automatic out_word_t rx_result(logic vld, logic [7:0] b, logic [7:0] pos,
                                          logic done, logic ferr, logic ovf,
                                          logic lr, logic cts);
    out_word_t r;
    r = '{byte_valid: vld, rx_byte: b, byte_position: pos, line_done: done,
          framing_error: ferr, line_overflow: ovf, line_ready: lr, clear_to_send: cts};
    return r;
  endfunction

  function automatic step_t plan(step_kind_t kind, logic [7:0] val, logic stop_lvl,
                                 logic tick_on, int count, logic typed_on,
                                 out_word_t typed);
    step_t s;
    s = '{kind: kind, val: val, stop_lvl: stop_lvl, tick_on: tick_on, count: count,
          typed_on: typed_on, typed: typed};
    return s;
  endfunction

  // Drive one word, record its expected result once accepted
  task automatic send_word(in_word_t w, bit typed_on, out_word_t typed);
    out_word_t p;
    in_chan.valid <= 1'b1;
    in_chan.data  <= w;
    do @(posedge clk); while (!in_chan.ready);
    p = predict_rx(w);
    expected_q.push_back(typed_on ? typed : p);
    if (w.tick || w.clear) live_words++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Serialize one byte: start bit, eight data bits, stop bit, one bit period each.
  // Stops at the stop-bit sample, or after upto ticks when upto is nonzero.
  task automatic send_frame(logic [7:0] b, logic stop_lvl, int upto, bit rough,
                            bit typed_on, out_word_t typed);
    int   p;
    int   last;
    int   k;
    logic lvl;
    p = 8 * (1 + int'(baud_div));
    last = (upto == 0) ? 9 * p : upto - 1;
    for (int o = 0; o <= last; o++) begin
      k = o / p;
      lvl = (k == 0) ? 1'b0 : (k <= 8) ? b[k - 1] : stop_lvl;
      if (rough) begin
        // drop in words without a tick, and glitches away from the sample points
        if ($urandom_range(0, 5) == 0)
          send_word(in_word_t'({1'b0, 1'b0, 1'($urandom)}), 1'b0, '0);
        if ((o % p) != 0 && $urandom_range(0, 15) == 0) lvl = ~lvl;
      end
      send_word(in_word_t'({1'b0, 1'b1, lvl}), typed_on && o == last, typed);
    end
  endtask

  // Drain all results, then write the divisor
  task automatic set_baud(logic [7:0] v);
    in_chan.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    baud_div = v;
  endtask

  // Mostly clean frames with random content, plus broken frames and line noise
  task automatic random_traffic(int n);
    int         stop_at;
    int         r;
    int         p;
    logic [7:0] b;
    stop_at = live_words + n;
    while (live_words < stop_at) begin
      r = $urandom_range(0, 99);
      p = 8 * (1 + int'(baud_div));
      if (r < 78) begin
        b = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
        send_frame(b, r < 70, 0, 1'b1, 1'b0, '0);
        repeat ($urandom_range(0, 4)) send_word(IDLE_TICK, 1'b0, '0);
      end else if (r < 84) begin
        send_frame(8'($urandom), 1'b1, $urandom_range(1, 9 * p), 1'b1, 1'b0, '0);
        send_word(in_word_t'({1'b1, 1'($urandom), 1'($urandom)}), 1'b0, '0);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 24))
          send_word(in_word_t'({$urandom_range(0, 15) == 0, 1'($urandom), 1'($urandom)}),
                    1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 20)) send_word(IDLE_TICK, 1'b0, '0);
      end
    end
  endtask

  task automatic diff_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with nothing expected, expected none got %h",
                 $time, out_chan.data);
      end else begin
        want = expected_q.pop_front();
        diff_field("byte_valid", want.byte_valid, out_chan.data.byte_valid);
        diff_field("rx_byte", want.rx_byte, out_chan.data.rx_byte);
        diff_field("byte_position", want.byte_position, out_chan.data.byte_position);
        diff_field("line_done", want.line_done, out_chan.data.line_done);
        diff_field("framing_error", want.framing_error, out_chan.data.framing_error);
        diff_field("line_overflow", want.line_overflow, out_chan.data.line_overflow);
        diff_field("line_ready", want.line_ready, out_chan.data.line_ready);
        diff_field("clear_to_send", want.clear_to_send, out_chan.data.clear_to_send);
      end
    end
  end

  // Stall the result side in short bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("uart_receiver_line_assembler: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t      steps[$];
    logic [7:0] b;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    baud_div = DIVISOR_RESET;
    clear_rx_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    steps = '{
      // no tick: nothing moves, clear-to-send still up from reset
      plan(ST_LEVEL, 8'h01, 1'b1, 1'b0, 3, 1'b1, rx_result(0, 8'h00, 8'h00, 0, 0, 0, 0, 1)),
      plan(ST_LEVEL, 8'h00, 1'b1, 1'b0, 2, 1'b0, '0),
      plan(ST_FRAME, 8'h00, 1'b1, 1'b1, 0, 1'b1, rx_result(1, 8'h00, 8'h00, 0, 0, 0, 0, 0)),
      plan(ST_FRAME, 8'hFF, 1'b1, 1'b1, 0, 1'b1, rx_result(1, 8'hFF, 8'h01, 0, 0, 0, 0, 0)),
      // low stop bit discards the line
      plan(ST_FRAME, 8'h55, 1'b0, 1'b1, 0, 1'b1, rx_result(0, 8'h00, 8'h00, 0, 1, 0, 0, 0)),
      plan(ST_FRAME, NEWLINE_CODE, 1'b1, 1'b1, 0, 1'b1,
           rx_result(1, NEWLINE_CODE, 8'h00, 1, 0, 0, 1, 0)),
      // clear wins over a tick with the line low
      plan(ST_CLEAR, 8'h00, 1'b1, 1'b1, 1, 1'b1, rx_result(0, 8'h00, 8'h00, 0, 0, 0, 0, 1)),
      plan(ST_LEVEL, 8'h01, 1'b1, 1'b1, 2, 1'b0, '0),
      plan(ST_BAUD, 8'd0, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_FRAME, 8'hA5, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_FRAME, NEWLINE_CODE, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_BAUD, 8'd255, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_FRAME, 8'h3C, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_BAUD, 8'd0, 1'b1, 1'b1, 0, 1'b0, '0),
      // fill the line past its end, then end it with a newline while full
      plan(ST_FILL, 8'h00, 1'b1, 1'b1, LINE_LEN + 1, 1'b0, '0),
      plan(ST_FRAME, NEWLINE_CODE, 1'b1, 1'b1, 0, 1'b1,
           rx_result(1, NEWLINE_CODE, 8'hFF, 1, 0, 1, 1, 0)),
      plan(ST_FRAME, 8'h61, 1'b1, 1'b1, 0, 1'b0, '0),
      // shorten the bit period while the count is already past the new one
      plan(ST_BAUD, 8'd20, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_PART, 8'h81, 1'b1, 1'b1, 60, 1'b0, '0),
      plan(ST_BAUD, 8'd0, 1'b1, 1'b1, 0, 1'b0, '0),
      plan(ST_LEVEL, 8'h00, 1'b1, 1'b1, 50, 1'b0, '0),
      plan(ST_LEVEL, 8'h01, 1'b1, 1'b1, 100, 1'b0, '0),
      // clear in the middle of a frame
      plan(ST_PART, 8'h42, 1'b1, 1'b1, 30, 1'b0, '0),
      plan(ST_CLEAR, 8'h01, 1'b1, 1'b0, 1, 1'b1, rx_result(0, 8'h00, 8'h00, 0, 0, 0, 0, 1))
    };

    // Walk the directed steps
    foreach (steps[i]) begin
      case (steps[i].kind)
        ST_LEVEL: begin
          for (int j = 0; j < steps[i].count; j++)
            send_word(in_word_t'({1'b0, steps[i].tick_on, steps[i].val[0]}),
                      steps[i].typed_on && j == steps[i].count - 1, steps[i].typed);
        end
        ST_FRAME: begin
          send_frame(steps[i].val, steps[i].stop_lvl, 0, 1'b0, steps[i].typed_on,
                     steps[i].typed);
        end
        ST_PART: begin
          send_frame(steps[i].val, 1'b1, steps[i].count, 1'b0, 1'b0, '0);
        end
        ST_FILL: begin
          repeat (steps[i].count) begin
            b = 8'($urandom_range(0, 255));
            if (b == NEWLINE_CODE) b = 8'h0B;
            send_frame(b, 1'b1, 0, 1'b0, 1'b0, '0);
          end
        end
        ST_CLEAR: begin
          send_word(in_word_t'({1'b1, steps[i].tick_on, steps[i].val[0]}),
                    steps[i].typed_on, steps[i].typed);
        end
        default: begin
          set_baud(steps[i].val);
        end
      endcase
    end

    // Random traffic over several bit periods; the last phase runs without stalls
    set_baud(8'd2);
    random_traffic(400);
    set_baud(8'd0);
    random_traffic(400);
    set_baud(8'($urandom_range(0, 3)));
    random_traffic(400);
    set_baud(8'd1);
    random_traffic(400);
    calm = 1'b1;
    set_baud(8'd3);
    random_traffic(400);

    in_chan.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("uart_receiver_line_assembler: match");
    end else begin
      $display("uart_receiver_line_assembler: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/urla_pkg.sv
src/urla_stream_if.sv
src/uart_receiver_line_assembler.sv
dv/testbench.sv
